FILE: design/assert_macros.svh
// Assertion shorthands for the deframer design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/sldf_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Shared constants, register codes and the result record of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sldf_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = PTR_W + 1;

    localparam logic [7:0] SYNC_FIRST  = 8'h5A;
    localparam logic [7:0] SYNC_SECOND = 8'hA5;

    localparam logic [7:0] SHORT_TAG_RESET = 8'h0B;
    localparam logic [7:0] SHORT_MAX_RESET = 8'd100;
    localparam logic [7:0] FRAME_MAX_RESET = 8'd128;

    localparam logic [1:0] CFG_SHORT_TAG = 2'd0;
    localparam logic [1:0] CFG_SHORT_MAX = 2'd1;
    localparam logic [1:0] CFG_FRAME_MAX = 2'd2;

    localparam logic KIND_SHORT  = 1'b0;
    localparam logic KIND_FRAMED = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] data;
        logic [3:0]  count;
        logic [7:0]  total;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

FILE: design/sync_length_xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// Sync-word, length and XOR-checksum deframer
// Steps: after the accept cycle, each window position is tested for a short packet, then for a sync
// word, length and XOR checksum; a failing position is dropped, a checked frame goes out in chunks.
// Throughput: one byte per scan; a stalled output holds the scan while a result waits.
// Reset clears the window pointers, the results held and the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sync_length_xor_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             packet_kind,
    output logic [63:0]      chunk_data,
    output logic [3:0]       chunk_count,
    output logic [7:0]       packet_total,
    output logic             packet_end,
    output logic             run_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int PW = sldf_pkg::PTR_W;
    localparam int FW = sldf_pkg::FILL_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK, ST_B0, ST_B1, ST_B2, ST_B3, ST_XOR, ST_EMIT, ST_PUSH, ST_FIN
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [PW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next, pos_reg, pos_next;
    logic [PW-1:0] k_reg, k_next;
    logic [7:0] b0_reg, b0_next, b2_reg, b2_next, acc_reg, acc_next;
    logic [7:0] total_reg, total_next;
    logic [63:0] chunk_reg, chunk_next;
    sldf_pkg::res_t res_reg, res_next, pend_reg, pend_next, out_reg, out_next;
    logic pend_valid_reg, pend_valid_next, out_valid_reg, out_valid_next;
    logic out_run_end_reg, out_run_end_next;
    logic [7:0] tag_reg, tag_next, smax_reg, smax_next, fmax_reg, fmax_next;

    logic          wr_en, rd_en;
    logic [PW-1:0] wr_addr, rd_off;
    logic [7:0]    rd_data;
    logic [FW-1:0] avail;
    logic [16:0]   tot17;
    logic [7:0]    acc_x;
    logic [2:0]    lane;
    logic [63:0]   data_x;
    logic          k_last, out_free;

    sldf_window_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (head_reg + rd_off),
        .rd_data (rd_data)
    );

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign packet_kind  = out_reg.kind;
    assign chunk_data   = out_reg.data;
    assign chunk_count  = out_reg.count;
    assign packet_total = out_reg.total;
    assign packet_end   = out_reg.last;
    assign run_end      = out_run_end_reg;

    assign avail    = fill_reg - pos_reg;
    assign tot17    = {1'b0, b2_reg, rd_data} + 17'd4;
    assign acc_x    = acc_reg ^ rd_data;
    assign lane     = k_reg[2:0];
    assign k_last   = ({1'b0, k_reg} == (total_reg - 8'd1));
    assign data_x   = ((lane == 3'd0) ? 64'd0 : chunk_reg)
                    | ({56'd0, rd_data} << {lane, 3'b000});
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        pos_next         = pos_reg;
        k_next           = k_reg;
        b0_next          = b0_reg;
        b2_next          = b2_reg;
        acc_next         = acc_reg;
        total_next       = total_reg;
        chunk_next       = chunk_reg;
        res_next         = res_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        out_next         = out_reg;
        out_run_end_next = out_run_end_reg;
        out_valid_next   = out_valid_reg && out_stall;
        tag_next         = tag_reg;
        smax_next        = smax_reg;
        fmax_next        = fmax_reg;
        wr_en            = 1'b0;
        wr_addr          = head_reg + fill_reg[PW-1:0];
        rd_en            = 1'b0;
        rd_off           = pos_reg[PW-1:0];

        if (cfg_valid)
        begin
            case (cfg_index)
                sldf_pkg::CFG_SHORT_TAG: tag_next  = cfg_data;
                sldf_pkg::CFG_SHORT_MAX: smax_next = cfg_data;
                sldf_pkg::CFG_FRAME_MAX: fmax_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    wr_en    = 1'b1;
                    pos_next = '0;
                    // A full window drops its oldest byte, whose slot takes the new one.
                    if (fill_reg == FW'(sldf_pkg::WINDOW_DEPTH))
                    begin
                        wr_addr   = head_reg;
                        head_next = head_reg + PW'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (avail < FW'(2))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_B0;
                end
            end
            ST_B0:
            begin
                b0_next    = rd_data;
                rd_en      = 1'b1;
                rd_off     = pos_reg[PW-1:0] + PW'(1);
                state_next = ST_B1;
            end
            ST_B1:
            begin
                if (b0_reg == tag_reg && rd_data <= smax_reg)
                begin
                    res_next.kind  = sldf_pkg::KIND_SHORT;
                    res_next.data  = {48'd0, rd_data, b0_reg};
                    res_next.count = 4'd2;
                    res_next.total = 8'd2;
                    res_next.last  = 1'b1;
                    pos_next       = pos_reg + FW'(2);
                    ret_next       = ST_CHK;
                    state_next     = ST_PUSH;
                end
                else if (avail < FW'(4))
                begin
                    state_next = ST_FIN;
                end
                else if (b0_reg != sldf_pkg::SYNC_FIRST || rd_data != sldf_pkg::SYNC_SECOND)
                begin
                    pos_next   = pos_reg + FW'(1);
                    state_next = ST_CHK;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_off     = pos_reg[PW-1:0] + PW'(2);
                    state_next = ST_B2;
                end
            end
            ST_B2:
            begin
                b2_next    = rd_data;
                rd_en      = 1'b1;
                rd_off     = pos_reg[PW-1:0] + PW'(3);
                state_next = ST_B3;
            end
            ST_B3:
            begin
                if (tot17 > {9'd0, fmax_reg} || tot17 > 17'(sldf_pkg::WINDOW_DEPTH))
                begin
                    pos_next   = pos_reg + FW'(1);
                    state_next = ST_CHK;
                end
                else if (17'(avail) < tot17)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    total_next = tot17[7:0];
                    k_next     = '0;
                    acc_next   = '0;
                    rd_en      = 1'b1;
                    state_next = ST_XOR;
                end
            end
            ST_XOR:
            begin
                rd_en = 1'b1;
                if (k_last)
                begin
                    // The frame checks out when all its bytes, checksum included, XOR to zero.
                    if (acc_x == 8'd0)
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pos_next   = pos_reg + FW'(1);
                        state_next = ST_CHK;
                    end
                end
                else
                begin
                    rd_off   = pos_reg[PW-1:0] + k_reg + PW'(1);
                    k_next   = k_reg + PW'(1);
                    acc_next = acc_x;
                end
            end
            ST_EMIT:
            begin
                rd_en      = 1'b1;
                rd_off     = pos_reg[PW-1:0] + k_reg + PW'(1);
                k_next     = k_reg + PW'(1);
                chunk_next = data_x;
                if (lane == 3'd7 || k_last)
                begin
                    res_next.kind  = sldf_pkg::KIND_FRAMED;
                    res_next.data  = data_x;
                    res_next.count = {1'b0, lane} + 4'd1;
                    res_next.total = total_reg;
                    res_next.last  = k_last;
                    state_next     = ST_PUSH;
                    if (k_last)
                    begin
                        pos_next = pos_reg + total_reg;
                        ret_next = ST_CHK;
                    end
                    else
                    begin
                        ret_next = ST_EMIT;
                    end
                end
            end
            ST_PUSH:
            begin
                // The newest result waits in the pending slot until the next one
                // or the end of the scan tells whether it closes the run.
                if (!pend_valid_reg)
                begin
                    pend_next       = res_reg;
                    pend_valid_next = 1'b1;
                    state_next      = ret_reg;
                end
                else if (out_free)
                begin
                    out_next         = pend_reg;
                    out_run_end_next = 1'b0;
                    out_valid_next   = 1'b1;
                    pend_next        = res_reg;
                    state_next       = ret_reg;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next         = pend_reg;
                        out_run_end_next = 1'b1;
                        out_valid_next   = 1'b1;
                        pend_valid_next  = 1'b0;
                    end
                    head_next  = head_reg + pos_reg[PW-1:0];
                    fill_next  = fill_reg - pos_reg;
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_CHK;
            head_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tag_reg        <= sldf_pkg::SHORT_TAG_RESET;
            smax_reg       <= sldf_pkg::SHORT_MAX_RESET;
            fmax_reg       <= sldf_pkg::FRAME_MAX_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            tag_reg        <= tag_next;
            smax_reg       <= smax_next;
            fmax_reg       <= fmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        b0_reg          <= b0_next;
        b2_reg          <= b2_next;
        acc_reg         <= acc_next;
        total_reg       <= total_next;
        chunk_reg       <= chunk_next;
        res_reg         <= res_next;
        pend_reg        <= pend_next;
        out_reg         <= out_next;
        out_run_end_reg <= out_run_end_next;
    end

    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(sldf_pkg::WINDOW_DEPTH), "window overfilled")
    `ASSERT_ALWAYS(a_pos_bound, pos_reg <= fill_reg, "scan ran past the window fill")
    `ASSERT_IMPLY(a_short_shape, out_valid_reg && out_reg.kind == sldf_pkg::KIND_SHORT, out_reg.count == 4'd2 && out_reg.last, "malformed short packet")
    `ASSERT_IMPLY(a_count_range, out_valid_reg, out_reg.count != 4'd0 && out_reg.count <= 4'd8, "chunk count out of range")

endmodule

`default_nettype wire

FILE: design/sldf_window_ram.sv
// ----------------------------------------------------------------------------
// Window RAM
// Byte store of the unparsed window: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sldf_window_ram (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [sldf_pkg::PTR_W-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    input  wire logic                      rd_en,
    input  wire logic [sldf_pkg::PTR_W-1:0] rd_addr,
    output logic      [7:0]                rd_data
);

    logic [7:0] mem [sldf_pkg::WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
